@@ hdl/nt_pkg.sv @@
package nt_pkg;

	localparam int NEIGHBORS_DEF = 16;
	localparam int TIME_W = 32;
	localparam int MAC_W = 48;
	localparam int NODE_W = 8;
	localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd10000;

	localparam logic [1:0] KIND_HEARD = 2'd0;
	localparam logic [1:0] KIND_PRUNE = 2'd1;
	localparam logic [1:0] KIND_LOOKUP = 2'd2;

	localparam logic [1:0] ACT_UPDATED = 2'd0;
	localparam logic [1:0] ACT_INSERTED = 2'd1;
	localparam logic [1:0] ACT_REPLACED = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [MAC_W-1:0] mac_addr;
		logic [NODE_W-1:0] node_ident;
		logic [TIME_W-1:0] now_ms;
	} req_t;

	typedef struct packed {
		logic found;
		logic [3:0] slot_index;
		logic [NODE_W-1:0] found_node;
		logic [TIME_W-1:0] found_time;
		logic [1:0] heard_action;
		logic [NODE_W-1:0] evicted_node;
		logic [4:0] pruned_count;
		logic [4:0] active_count;
	} rsp_t;

	typedef struct packed {
		logic [MAC_W-1:0] mac;
		logic [NODE_W-1:0] node;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic start;
		logic issue;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} stat_t;

endpackage

@@ hdl/nt_ram.sv @@
module nt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/nt_ctrl.sv @@
module nt_ctrl #(
	parameter int NEIGHBORS = nt_pkg::NEIGHBORS_DEF,
	localparam int SW = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	output nt_pkg::cmd_t   cmd,
	output logic [SW-1:0]  addr,
	input  nt_pkg::stat_t  st
);
	import nt_pkg::*;

	state_t state_q, state_d;
	logic [SW-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd = '0;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.start = 1'b1;
					cnt_d = '0;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				cnt_d = cnt_q + SW'(1);
				if (cnt_q == SW'(NEIGHBORS - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (st.out_free) begin
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign addr = cnt_q;

`ifndef SYNTHESIS
	a_start_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (state_q == ST_SCAN) && (cnt_q == '0))
		else $error("scan did not start at slot zero");
	a_drain_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> $past(cmd.issue))
		else $error("drain entered without a preceding scan read");
`endif

endmodule

@@ hdl/nt_dp.sv @@
module nt_dp #(
	parameter int NEIGHBORS = nt_pkg::NEIGHBORS_DEF,
	localparam int SW = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1,
	localparam int CW = $clog2(NEIGHBORS + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  nt_pkg::req_t              req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output nt_pkg::rsp_t              rsp,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [nt_pkg::TIME_W-1:0] cfg_data,
	input  nt_pkg::cmd_t              cmd,
	input  logic [SW-1:0]             addr,
	output nt_pkg::stat_t             st
);
	import nt_pkg::*;

	logic [TIME_W-1:0] timeout_q;
	req_t req_q;
	logic [NEIGHBORS-1:0] active_q;
	logic [CW-1:0] cnt_q, cnt_nxt;
	logic [CW-1:0] pruned_q;

	logic vld_s1;
	logic [SW-1:0] idx_s1;
	entry_t rd;

	logic match_q, free_q;
	logic [SW-1:0] match_idx_q, free_idx_q, best_idx_q;
	logic [NODE_W-1:0] match_node_q, best_node_q;
	logic [TIME_W-1:0] match_time_q, best_time_q;

	logic rsp_valid_q;
	rsp_t rsp_q, rsp_d;

	logic act, hit, old, wr_en, set_act;
	logic [SW-1:0] wr_idx;
	logic [1:0] action;
	entry_t wr_data;

	nt_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(NEIGHBORS)
	) u_entry_ram (
		.clk(clk),
		.we(wr_en),
		.waddr(wr_idx),
		.wdata(wr_data),
		.raddr(addr),
		.rdata(rd)
	);

	assign cfg_ready = 1'b1;
	assign act = vld_s1 && active_q[idx_s1];
	assign hit = act && (rd.mac == req_q.mac_addr);
	assign old = act && (req_q.kind == KIND_PRUNE) &&
		((req_q.now_ms - rd.stamp) > timeout_q);

	always_comb begin
		action = ACT_REPLACED;
		wr_idx = best_idx_q;
		if (match_q) begin
			action = ACT_UPDATED;
			wr_idx = match_idx_q;
		end else if (free_q) begin
			action = ACT_INSERTED;
			wr_idx = free_idx_q;
		end
	end

	assign wr_en = cmd.commit && (req_q.kind == KIND_HEARD);
	assign set_act = wr_en && (action == ACT_INSERTED);
	assign cnt_nxt = cnt_q + CW'(set_act);
	assign wr_data = '{mac: req_q.mac_addr, node: req_q.node_ident, stamp: req_q.now_ms};

	always_comb begin
		rsp_d = '0;
		rsp_d.active_count = 5'(cnt_nxt);
		unique case (req_q.kind)
			KIND_HEARD: begin
				rsp_d.slot_index = 4'(wr_idx);
				rsp_d.heard_action = action;
				if (action == ACT_REPLACED) begin
					rsp_d.evicted_node = best_node_q;
				end
			end
			KIND_PRUNE: begin
				rsp_d.pruned_count = 5'(pruned_q);
			end
			KIND_LOOKUP: begin
				if (match_q) begin
					rsp_d.found = 1'b1;
					rsp_d.slot_index = 4'(match_idx_q);
					rsp_d.found_node = match_node_q;
					rsp_d.found_time = match_time_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			active_q <= '0;
			cnt_q <= '0;
			vld_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				timeout_q <= cfg_data;
			end
			vld_s1 <= cmd.issue;
			if (old) begin
				active_q[idx_s1] <= 1'b0;
				cnt_q <= cnt_q - CW'(1);
			end else if (set_act) begin
				active_q[wr_idx] <= 1'b1;
				cnt_q <= cnt_nxt;
			end
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr;
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
		if (cmd.start) begin
			req_q <= req;
			match_q <= 1'b0;
			free_q <= 1'b0;
			pruned_q <= '0;
		end else if (vld_s1) begin
			if (hit && !match_q) begin
				match_q <= 1'b1;
				match_idx_q <= idx_s1;
				match_node_q <= rd.node;
				match_time_q <= rd.stamp;
			end
			if (!active_q[idx_s1] && !free_q) begin
				free_q <= 1'b1;
				free_idx_q <= idx_s1;
			end
			if ((idx_s1 == '0) || (rd.stamp < best_time_q)) begin
				best_idx_q <= idx_s1;
				best_node_q <= rd.node;
				best_time_q <= rd.stamp;
			end
			if (old) begin
				pruned_q <= pruned_q + CW'(1);
			end
		end
	end

	assign st.out_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

`ifndef SYNTHESIS
	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == CW'($countones(active_q)))
		else $error("active count out of step with active bits");
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp_valid_q)
		else $error("committed result not presented");
	a_heard_fills: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (active_q != '0))
		else $error("table empty after heard transfer");
`endif

endmodule

@@ hdl/neighbor_table_with_timeout.sv @@
// Neighbor table keyed by 48-bit MAC with timestamp aging.
// req channel: req_valid / req_stall with a req_t payload (kind, mac_addr,
// node_ident, now_ms). A transfer happens when req_valid is high and
// req_stall is low. Kinds: heard (update, insert or replace oldest),
// prune (drop entries older than the timeout), lookup (first active match).
// rsp channel: rsp_valid / rsp_stall with one rsp_t per request.
// cfg channel: cfg_valid / cfg_ready with cfg_data, the prune timeout in ms;
// cfg_ready is always high. Write it only while no request is in flight.
// Each request is scanned slot by slot, with one read of the entry memory
// per slot; the controller then drains the last read and commits the result
// to the output register, and takes no new request until that commit.
// A new request is taken while an earlier result still waits in the output
// register; a stalled result holds and blocks only the commit of the next.
// Reset: all entries inactive, timeout 10000 ms, no result pending.
module neighbor_table_with_timeout #(
	parameter int NEIGHBORS = nt_pkg::NEIGHBORS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  nt_pkg::req_t              req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output nt_pkg::rsp_t              rsp,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [nt_pkg::TIME_W-1:0] cfg_data
);
	import nt_pkg::*;

	localparam int SW = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;

	cmd_t cmd;
	stat_t st;
	logic [SW-1:0] addr;

	nt_ctrl #(
		.NEIGHBORS(NEIGHBORS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.cmd(cmd),
		.addr(addr),
		.st(st)
	);

	nt_dp #(
		.NEIGHBORS(NEIGHBORS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.addr(addr),
		.st(st)
	);

endmodule

@@ test/neighbor_table_with_timeout_test.sv @@
`timescale 1ns / 100ps

module neighbor_table_with_timeout_test;
	import nt_pkg::*;

	localparam int NEIGHBORS = NEIGHBORS_DEF;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int PHASES = 5;
	localparam int PHASE_ITEMS = 90;
	localparam int MAC_POOL = 24;
	localparam int IDLE_PCT = 19;
	localparam int HOLD_CYCLES = 250;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		req_t stim;
		bit typed;
		rsp_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [TIME_W-1:0] cfg_data = '0;

	logic [MAC_W-1:0] nb_mac [NEIGHBORS];
	logic [NODE_W-1:0] nb_node [NEIGHBORS];
	logic [TIME_W-1:0] nb_stamp [NEIGHBORS];
	bit nb_live [NEIGHBORS];
	logic [TIME_W-1:0] age_limit = TIMEOUT_RST;

	logic [TIME_W-1:0] clock_ms;
	logic [MAC_W-1:0] mac_pool [MAC_POOL];
	logic [TIME_W-1:0] limit_plan [PHASES];
	row_t rows [$];
	rsp_t want_q [$];
	rsp_t head_rsp;
	int bad_count = 0;
	int unsigned cycle_count = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit hold_seen = 1'b0;

	neighbor_table_with_timeout #(
		.NEIGHBORS(NEIGHBORS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic rsp_t table_apply(input req_t r);
		rsp_t o;
		int hit;
		int victim;
		int live;
		int pruned;
		logic [TIME_W-1:0] oldest;
		logic [TIME_W-1:0] age;
		o = '0;
		hit = -1;
		victim = 0;
		live = 0;
		pruned = 0;
		oldest = '1;
		case (r.kind)
			KIND_HEARD: begin
				for (int i = 0; i < NEIGHBORS; i++)
					if (hit < 0 && nb_live[i] && nb_mac[i] == r.mac_addr)
						hit = i;
				if (hit >= 0) begin
					nb_stamp[hit] = r.now_ms;
					nb_node[hit] = r.node_ident;
					o.heard_action = ACT_UPDATED;
				end else begin
					for (int i = 0; i < NEIGHBORS; i++)
						if (hit < 0 && !nb_live[i])
							hit = i;
					if (hit >= 0) begin
						o.heard_action = ACT_INSERTED;
					end else begin
						for (int i = 0; i < NEIGHBORS; i++)
							if (nb_stamp[i] < oldest) begin
								oldest = nb_stamp[i];
								victim = i;
							end
						hit = victim;
						o.heard_action = ACT_REPLACED;
						o.evicted_node = nb_node[victim];
					end
					nb_mac[hit] = r.mac_addr;
					nb_node[hit] = r.node_ident;
					nb_stamp[hit] = r.now_ms;
					nb_live[hit] = 1'b1;
				end
				o.slot_index = 4'(hit);
			end
			KIND_PRUNE: begin
				for (int i = 0; i < NEIGHBORS; i++) begin
					age = r.now_ms - nb_stamp[i];
					if (nb_live[i] && age > age_limit) begin
						nb_live[i] = 1'b0;
						pruned++;
					end
				end
				o.pruned_count = 5'(pruned);
			end
			KIND_LOOKUP: begin
				for (int i = 0; i < NEIGHBORS; i++)
					if (hit < 0 && nb_live[i] && nb_mac[i] == r.mac_addr)
						hit = i;
				if (hit >= 0) begin
					o.found = 1'b1;
					o.slot_index = 4'(hit);
					o.found_node = nb_node[hit];
					o.found_time = nb_stamp[hit];
				end
			end
			default: begin
			end
		endcase
		for (int i = 0; i < NEIGHBORS; i++)
			if (nb_live[i])
				live++;
		o.active_count = 5'(live);
		return o;
	endfunction

	function automatic rsp_t mk_rsp(input logic found, input logic [3:0] slot,
			input logic [7:0] fnode, input logic [31:0] ftime, input logic [1:0] act,
			input logic [7:0] evict, input logic [4:0] pruned, input logic [4:0] active);
		rsp_t o;
		o.found = found;
		o.slot_index = slot;
		o.found_node = fnode;
		o.found_time = ftime;
		o.heard_action = act;
		o.evicted_node = evict;
		o.pruned_count = pruned;
		o.active_count = active;
		return o;
	endfunction

	function automatic void add_row(input logic [1:0] kind, input logic [47:0] mac,
			input logic [7:0] node, input logic [31:0] now, input bit typed, input rsp_t want);
		row_t w;
		w.stim.kind = kind;
		w.stim.mac_addr = mac;
		w.stim.node_ident = node;
		w.stim.now_ms = now;
		w.typed = typed;
		w.want = want;
		rows.push_back(w);
	endfunction

	function automatic req_t random_item(input logic [TIME_W-1:0] span);
		req_t r;
		int pick;
		logic [63:0] wide;
		pick = $urandom_range(0, 99);
		wide = {$urandom, $urandom};
		if (pick < 52)
			r.kind = KIND_HEARD;
		else if (pick < 68)
			r.kind = KIND_PRUNE;
		else if (pick < 95)
			r.kind = KIND_LOOKUP;
		else
			r.kind = KIND_UNUSED;
		if ($urandom_range(0, 9) == 0)
			r.mac_addr = wide[47:0];
		else
			r.mac_addr = mac_pool[$urandom_range(0, MAC_POOL - 1)];
		r.node_ident = 8'($urandom_range(0, 255));
		if (r.kind == KIND_HEARD && $urandom_range(0, 99) < 20)
			r.now_ms = clock_ms - $urandom_range(0, span);
		else
			r.now_ms = clock_ms;
		clock_ms = clock_ms + $urandom_range(0, span);
		return r;
	endfunction

	task automatic send(input req_t r, input bit typed, input rsp_t want);
		rsp_t got;
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		got = table_apply(r);
		want_q.push_back(typed ? want : got);
	endtask

	task automatic drain();
		while (want_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_age_limit(input logic [TIME_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		age_limit = v;
	endtask

	task automatic note_bad(input string what, input rsp_t e, input rsp_t a);
		bad_count++;
		if (bad_count <= 10)
			$display("%s: found %0d/%0d slot %0d/%0d node %h/%h time %h/%h act %0d/%0d evict %h/%h pruned %0d/%0d active %0d/%0d",
				what, e.found, a.found, e.slot_index, a.slot_index, e.found_node,
				a.found_node, e.found_time, a.found_time, e.heard_action, a.heard_action,
				e.evicted_node, a.evicted_node, e.pruned_count, a.pruned_count,
				e.active_count, a.active_count);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (want_q.size() == 0) begin
				note_bad("unexpected transfer", '0, rsp);
			end else begin
				head_rsp = want_q.pop_front();
				if (rsp.found !== head_rsp.found || rsp.slot_index !== head_rsp.slot_index ||
						rsp.found_node !== head_rsp.found_node ||
						rsp.found_time !== head_rsp.found_time ||
						rsp.heard_action !== head_rsp.heard_action ||
						rsp.evicted_node !== head_rsp.evicted_node ||
						rsp.pruned_count !== head_rsp.pruned_count ||
						rsp.active_count !== head_rsp.active_count)
					note_bad("mismatch", head_rsp, rsp);
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_seen) begin
				hold_seen = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	initial begin
		logic [63:0] wide;
		logic [TIME_W-1:0] span;
		for (int i = 0; i < MAC_POOL; i++) begin
			wide = {$urandom, $urandom};
			if (i < MAC_POOL / 2)
				mac_pool[i] = wide[47:0];
			else
				mac_pool[i] = mac_pool[0] ^ (48'h1 << $urandom_range(0, MAC_W - 1));
		end
		limit_plan[0] = 32'd0;
		limit_plan[1] = 32'hFFFF_FFFF;
		limit_plan[2] = 32'd50;
		limit_plan[3] = 32'($urandom_range(200, 20000));
		limit_plan[4] = 32'd1000;

		add_row(KIND_LOOKUP, 48'h0, 8'h00, 32'h0, 1'b1, mk_rsp(0, 0, 0, 0, '0, 0, 0, 0));
		add_row(KIND_UNUSED, '1, 8'hFF, '1, 1'b1, mk_rsp(0, 0, 0, 0, '0, 0, 0, 0));
		add_row(KIND_HEARD, '1, 8'hFF, 32'd0, 1'b1, mk_rsp(0, 0, 0, 0, ACT_INSERTED, 0, 0, 1));
		add_row(KIND_HEARD, 48'h0, 8'h00, 32'd10, 1'b1,
			mk_rsp(0, 1, 0, 0, ACT_INSERTED, 0, 0, 2));
		add_row(KIND_LOOKUP, '1, 8'h00, 32'd0, 1'b1, mk_rsp(1, 0, 8'hFF, 0, '0, 0, 0, 2));
		add_row(KIND_PRUNE, 48'h0, 8'h00, 32'd10000, 1'b1, mk_rsp(0, 0, 0, 0, '0, 0, 0, 2));
		add_row(KIND_PRUNE, 48'h0, 8'h00, 32'd10001, 1'b1, mk_rsp(0, 0, 0, 0, '0, 0, 1, 1));
		add_row(KIND_LOOKUP, '1, 8'h00, 32'd0, 1'b1, mk_rsp(0, 0, 0, 0, '0, 0, 0, 1));
		add_row(KIND_HEARD, '1, 8'h5A, '1, 1'b1, mk_rsp(0, 0, 0, 0, ACT_INSERTED, 0, 0, 2));
		add_row(KIND_HEARD, 48'h0, 8'h01, '1, 1'b1, mk_rsp(0, 1, 0, 0, ACT_UPDATED, 0, 0, 2));
		for (int i = 2; i < NEIGHBORS; i++)
			add_row(KIND_HEARD, 48'(i), 8'(i), '1, 1'b0, '0);
		add_row(KIND_HEARD, 48'h10, 8'hA5, '1, 1'b1,
			mk_rsp(0, 0, 0, 0, ACT_REPLACED, 8'h5A, 0, 16));
		add_row(KIND_PRUNE, 48'h0, 8'h00, 32'd20000, 1'b1, mk_rsp(0, 0, 0, 0, '0, 0, 16, 0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send(rows[i].stim, rows[i].typed, rows[i].want);
		req_valid <= 1'b0;
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			write_age_limit(limit_plan[ph]);
			calm = (ph == 2);
			clock_ms = $urandom;
			span = (age_limit > 32'h1000_0000) ? 32'h3000_0000 : age_limit / 4 + 2;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 3 && n == 10)
					hold_req = 1'b1;
				send(random_item(span), 1'b0, '0);
			end
			req_valid <= 1'b0;
			drain();
		end
		calm = 1'b0;

		repeat (2 * (NEIGHBORS + 3)) @(posedge clk);
		if (bad_count == 0 && want_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
